/* rtl/b64e_pkg.sv */
// b64e_pkg: shared types, constants and the sextet-to-character function
// for the base64 stream encoder. No dependencies.
package b64e_pkg;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned MaxChars   = 4;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef logic [1:0] char_idx_t;

    // one classified request: up to four characters, index of the last one,
    // and whether the request closes the message
    typedef struct packed {
        logic [MaxChars-1:0][7:0] chars;
        char_idx_t                last_idx;
        logic                     fin;
    } cmd_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] ext;
        logic [7:0] res;
        ext = {2'b00, v};
        if (v < 6'd26)
        begin
            res = ext + 8'h41;
        end
        else if (v < 6'd52)
        begin
            res = ext + 8'd71;
        end
        else if (v < 6'd62)
        begin
            res = ext - 8'd4;
        end
        else if (v == 6'd62)
        begin
            res = 8'h2B;
        end
        else
        begin
            res = 8'h2F;
        end
        return res;
    endfunction

endpackage

/* rtl/b64e_front.sv */
// b64e_front: takes raw bytes, tracks group phase and leftover bits, and
// turns each byte into a character request. Depends on b64e_pkg.
module b64e_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic          final_byte,
    output b64e_pkg::cmd_t cmd
);
    import b64e_pkg::*;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] left_reg;
    logic [3:0] left_next;

    always_comb
    begin
        cmd          = '0;
        cmd.fin      = final_byte;
        phase_next   = phase_reg;
        left_next    = left_reg;
        unique case (phase_reg)
            2'd1:
            begin
                cmd.chars[0] = sextet_char({left_reg[1:0], data_byte[7:4]});
                left_next    = data_byte[3:0];
                phase_next   = 2'd2;
                if (final_byte)
                begin
                    cmd.chars[1] = sextet_char({data_byte[3:0], 2'b00});
                    cmd.chars[2] = PAD_CHAR;
                    cmd.last_idx = 2'd2;
                end
            end
            2'd2:
            begin
                cmd.chars[0] = sextet_char({left_reg, data_byte[7:6]});
                cmd.chars[1] = sextet_char(data_byte[5:0]);
                cmd.last_idx = 2'd1;
                left_next    = 4'd0;
                phase_next   = 2'd0;
            end
            default:
            begin
                cmd.chars[0] = sextet_char(data_byte[7:2]);
                left_next    = {2'b00, data_byte[1:0]};
                phase_next   = 2'd1;
                if (final_byte)
                begin
                    cmd.chars[1] = sextet_char({data_byte[1:0], 4'b0000});
                    cmd.chars[2] = PAD_CHAR;
                    cmd.chars[3] = PAD_CHAR;
                    cmd.last_idx = 2'd3;
                end
            end
        endcase
        if (final_byte)
        begin
            phase_next = 2'd0;
            left_next  = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            left_reg  <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

/* rtl/b64e_queue.sv */
// b64e_queue: short register queue of character requests between the
// front and back parts. Depends on b64e_pkg.
module b64e_queue
#(
    parameter int unsigned DEPTH = b64e_pkg::QueueDepth
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64e_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output b64e_pkg::cmd_t head_cmd,
    output logic           empty
);
    import b64e_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    cmd_t            slot_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == FullCnt);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/b64e_back.sv */
// b64e_back: walks the characters of the oldest request one per cycle, while
// the receiver pops, into the result register. Depends on b64e_pkg.
module b64e_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  b64e_pkg::cmd_t head_cmd,
    input  logic           head_empty,
    output logic           head_pop,
    input  logic           pop,
    output logic           empty,
    output logic [7:0]     out_char,
    output logic           run_last,
    output logic           message_end
);
    import b64e_pkg::*;

    char_idx_t  idx_reg;
    logic       valid_reg;
    logic [7:0] char_reg;
    logic       run_last_reg;
    logic       end_reg;
    logic       load;
    logic       at_last;

    assign load     = !head_empty && (!valid_reg || pop);
    assign at_last  = (idx_reg == head_cmd.last_idx);
    assign head_pop = load && at_last;

    assign empty       = !valid_reg;
    assign out_char    = char_reg;
    assign run_last    = run_last_reg;
    assign message_end = end_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg     <= head_cmd.chars[idx_reg];
            run_last_reg <= at_last;
            end_reg      <= at_last && head_cmd.fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= at_last ? '0 : idx_reg + 1'b1;
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/base64_stream_encoder.sv */
// base64_stream_encoder: top level, front classifier, request queue and
// character back end. Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
//
// Usage:
//   Input side is a queue: present data_byte and final_byte with push; the
//   byte is taken on a clock edge where push is high and full is low. Raise
//   final_byte on the last byte of a message; the block then adds any
//   partial character and '=' padding due and starts afresh for the next byte.
//   Result side is a queue: while empty is low, out_char, run_last and
//   message_end show the oldest character; pop takes it.
//   On an idle block a taken byte's request is written into the request
//   queue, then its first character is loaded into the result register.
//   While the receiver pops, the back end emits one character per cycle; a
//   byte yields one or two characters (three or four for a final byte that
//   closes a one- or two-byte group); a steady stream gives about 4
//   characters per 3 bytes. The request queue sets how far input runs ahead.
//   A stalled receiver holds the current character; the queue fills and full
//   rises. Reset empties queue and result register and clears group phase.
module base64_stream_encoder
#(
    parameter int unsigned QUEUE_DEPTH = b64e_pkg::QueueDepth
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       message_end
);
    import b64e_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic accept;
    logic head_empty;
    logic head_pop;

    assign accept = push && !full;

    b64e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .cmd        (front_cmd)
    );

    b64e_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_cmd (front_cmd),
        .full     (full),
        .pop      (head_pop),
        .head_cmd (head_cmd),
        .empty    (head_empty)
    );

    b64e_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .head_empty  (head_empty),
        .head_pop    (head_pop),
        .pop         (pop),
        .empty       (empty),
        .out_char    (out_char),
        .run_last    (run_last),
        .message_end (message_end)
    );

endmodule

/* rtl/b64e_checker.sv */
// b64e_checker: port-level checks for base64_stream_encoder, bound to the
// top level. Depends on b64e_pkg.
module b64e_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       pop,
    input logic       empty,
    input logic [7:0] out_char,
    input logic       run_last,
    input logic       message_end
);
    import b64e_pkg::*;

    a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((out_char >= 8'h41 && out_char <= 8'h5A) ||
                    (out_char >= 8'h61 && out_char <= 8'h7A) ||
                    (out_char >= 8'h30 && out_char <= 8'h39) ||
                    out_char == 8'h2B || out_char == 8'h2F || out_char == PAD_CHAR))
        else $error("illegal output character");

    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && message_end) |-> run_last)
        else $error("message end without run end");

    a_pad_run_ends_msg: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_char == PAD_CHAR && run_last) |-> message_end)
        else $error("padding run does not close the message");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(run_last)))
        else $error("result changed while stalled");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .pop         (pop),
    .empty       (empty),
    .out_char    (out_char),
    .run_last    (run_last),
    .message_end (message_end)
);
